// ----- src/firdf_pkg.sv -----
// Shared types and fixed field widths for the direct-form FIR filter.
// Depends on nothing; imported by fir_filter_direct_form.
package firdf_pkg;

	localparam int TAPS_W     = 9;
	localparam int COEF_W     = 18;
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = COEF_W + SAMPLE_W;
	localparam int FRAC_BITS  = 17;

	localparam logic [TAPS_W-1:0] TAPS_RESET = 9'd257;

	// Operation codes carried in the op field
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

// ----- src/firdf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the tap table and the delay lines.
module firdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/fir_filter_direct_form.sv -----
// Multi-channel direct-form FIR filter: one shared multiply-accumulate unit
// walks the tap table for each sample. Depends on firdf_pkg and firdf_ram.
//
// Input channel (in_valid / in_stall): op = 0 loads coefficient into tap_index
// of the shared tap table (dropped when tap_index >= MAX_TAPS); op = 1 pushes
// sample_in into the delay line of 'channel' and yields one filtered word
// (dropped when channel >= CHANNELS). Output channel (out_valid / out_stall):
// sample_out, rounded half away from zero and saturated to 16 bits, with
// out_channel. cfg_write / cfg_data set taps_in_use (above MAX_TAPS acts as
// MAX_TAPS, zero gives a zero result); write it only while idle.
// Flow: a coefficient load is written into the tap table as it is accepted.
// A filtered word is built one tap per cycle through the single multiplier:
// registered tap and delay-line reads, the product register and the
// accumulator, then rounding into the output register. in_stall stays high
// until that word is loaded there, so no new sample is taken before then.
// Reset: a clearing pass over all CHANNELS * MAX_TAPS delay-line slots zeroes
// the tap table and delay lines with in_stall high; taps_in_use resets to 257.
// Stall: the output register holds its word while out_stall is high; the next
// word is accepted meanwhile, and a finished sum waits in the rounding stage.
module fir_filter_direct_form #(
	parameter int MAX_TAPS = 257,
	parameter int CHANNELS = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [firdf_pkg::TAPS_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic                           channel,
	input  logic [firdf_pkg::TAPS_W-1:0]   tap_index,
	input  logic signed [firdf_pkg::COEF_W-1:0]   coefficient,
	input  logic signed [firdf_pkg::SAMPLE_W-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [firdf_pkg::SAMPLE_W-1:0] sample_out,
	output logic                           out_channel
);

	import firdf_pkg::*;

	localparam int TW    = $clog2(MAX_TAPS);
	localparam int KW    = $clog2(MAX_TAPS + 1);
	localparam int DEPTH = CHANNELS * MAX_TAPS;
	localparam int DAW   = $clog2(DEPTH);
	localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32'sd32767);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32'sd32768);
	localparam logic signed [ACC_W-1:0] BIAS_POS = ACC_W'(32'sd65536);
	localparam logic signed [ACC_W-1:0] BIAS_NEG = ACC_W'(32'sd65535);

	state_t state_q, state_d;

	// Control and datapath registers
	logic [TAPS_W-1:0] taps_cfg_q;
	logic [DAW-1:0]    clr_q;
	logic [TW-1:0]     newest_q [CHANNELS];
	logic [KW-1:0]     k_q;
	logic [KW-1:0]     taps_q;
	logic [TW-1:0]     at_q;
	logic [DAW-1:0]    base_q;
	logic              ch_q;
	logic signed [ACC_W-1:0] acc_q;
	logic              valid_s1;
	logic              valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic              out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic              out_channel_q;

	// Combinational control
	logic              accept;
	logic              do_load;
	logic              do_filter;
	logic [CHW-1:0]    chi;
	logic [TW-1:0]     pos_next;
	logic              issue;
	logic              out_free;
	logic              out_load;
	logic signed [ACC_W-1:0] rnd;
	logic signed [SAMPLE_W-1:0] sat_val;

	// RAM ports
	logic              tap_we;
	logic [TW-1:0]     tap_waddr;
	logic signed [COEF_W-1:0] tap_wdata;
	logic signed [COEF_W-1:0] tap_rdata;
	logic              dly_we;
	logic [DAW-1:0]    dly_waddr;
	logic signed [SAMPLE_W-1:0] dly_wdata;
	logic [DAW-1:0]    dly_raddr;
	logic signed [SAMPLE_W-1:0] dly_rdata;

	firdf_ram #(
		.WIDTH(COEF_W),
		.DEPTH(MAX_TAPS)
	) u_tap_ram (
		.clk  (clk),
		.we   (tap_we),
		.waddr(tap_waddr),
		.wdata(tap_wdata),
		.raddr(k_q[TW-1:0]),
		.rdata(tap_rdata)
	);

	firdf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_dly_ram (
		.clk  (clk),
		.we   (dly_we),
		.waddr(dly_waddr),
		.wdata(dly_wdata),
		.raddr(dly_raddr),
		.rdata(dly_rdata)
	);

	// Decode the incoming word
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign do_load   = accept && (op == OP_LOAD) && (32'(tap_index) < MAX_TAPS);
	assign do_filter = accept && (op == OP_FILTER) && (32'(channel) < CHANNELS);
	assign chi       = CHW'(channel);
	assign pos_next  = (newest_q[chi] >= TW'(MAX_TAPS - 1)) ? '0 : newest_q[chi] + 1'b1;
	assign issue     = (state_q == ST_RUN) && (k_q != taps_q);
	assign dly_raddr = base_q + DAW'(at_q);

	// Round half away from zero, then saturate
	assign rnd = (acc_q + (acc_q[ACC_W-1] ? BIAS_NEG : BIAS_POS)) >>> FRAC_BITS;
	always_comb begin
		if (rnd > SAT_HI) begin
			sat_val = SAMPLE_W'(SAT_HI);
		end else if (rnd < SAT_LO) begin
			sat_val = SAMPLE_W'(SAT_LO);
		end else begin
			sat_val = SAMPLE_W'(rnd);
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_DONE) && out_free;

	// Next state and RAM write control
	always_comb begin
		state_d   = state_q;
		tap_we    = 1'b0;
		tap_waddr = TW'(tap_index);
		tap_wdata = coefficient;
		dly_we    = 1'b0;
		dly_waddr = DAW'(32'(channel) * MAX_TAPS) + DAW'(pos_next);
		dly_wdata = sample_in;
		case (state_q)
			ST_CLEAR: begin
				tap_we    = (32'(clr_q) < MAX_TAPS);
				tap_waddr = clr_q[TW-1:0];
				tap_wdata = '0;
				dly_we    = 1'b1;
				dly_waddr = clr_q;
				dly_wdata = '0;
				if (clr_q == DAW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				tap_we = do_load;
				dly_we = do_filter;
				if (do_filter) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!issue) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_cfg_q <= TAPS_RESET;
			clr_q      <= '0;
		end else begin
			if (cfg_write) begin
				taps_cfg_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Newest slot of each delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				newest_q[i] <= '0;
			end
		end else if (do_filter) begin
			newest_q[chi] <= pos_next;
		end
	end

	// Tap walk: set up on accept, advance one tap per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (do_filter) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Per-word payload held for the walk
	always_ff @(posedge clk) begin
		if (do_filter) begin
			ch_q   <= channel;
			base_q <= DAW'(32'(channel) * MAX_TAPS);
			at_q   <= pos_next;
			taps_q <= (32'(taps_cfg_q) > MAX_TAPS) ? KW'(MAX_TAPS) : KW'(taps_cfg_q);
		end else if (issue) begin
			at_q <= (at_q == '0) ? TW'(MAX_TAPS - 1) : at_q - 1'b1;
		end
	end

	// Multiply, then accumulate
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= tap_rdata * dly_rdata;
		end
		if (do_filter) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q  <= sat_val;
			out_channel_q <= ch_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign out_channel = out_channel_q;

endmodule
